### design/base32_lowercase_decoder_assert.svh
// Assertion macros for the base32 lowercase decoder checker.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef BASE32_LOWERCASE_DECODER_ASSERT_SVH
`define BASE32_LOWERCASE_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define B32D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b32d assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define B32D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b32d assertion failed");

`endif

### design/b32d_pkg.sv
// Shared types, codes and the character decode function of the base32 decoder.
// No dependencies.
package b32d_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TRAIL    = 2'd2
  } status_e;

  // One result item as it travels through the output queue.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       finished;
    status_e    status;
  } result_t;

  // Results produced by one accepted item, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharZ     = 8'h7a;
  localparam logic [7:0] CharTwo   = 8'h32;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] DigitBase = 8'd26;

  // Returns {valid, value}: the 5-bit value of a lowercase base32 character.
  function automatic logic [5:0] sym_decode(logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CharA && c <= CharZ) begin
      d = c - CharA;
      return {1'b1, d[4:0]};
    end
    if (c >= CharTwo && c <= CharSeven) begin
      d = c - CharTwo + DigitBase;
      return {1'b1, d[4:0]};
    end
    return 6'd0;
  endfunction

endpackage

### design/b32d_result_fifo.sv
// Four-entry result queue that takes up to two results per cycle and gives one.
// Depends on b32d_pkg for result_t and push_t.
module b32d_result_fifo
  import b32d_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam int Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  // Room for two more results keeps a double-result item from overflowing.
  assign room_o      = count_q <= 3'(Depth - 2);
  assign out_valid_o = count_q != 3'd0;
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_i.count} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage; the second result lands just after the first.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

endmodule

### design/base32_lowercase_decoder.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// input    | in        | in_valid_i/in_ready_o  | symbol_i, last_symbol_i
// output   | out       | out_valid_o/out_ready_i| out_byte_o, byte_valid_o, finished_o, status_o
//
// Each transfer on the input is decoded in the cycle it is accepted and its results
// (zero, one or two) are written into a four-entry result queue, so one character per
// cycle is taken while each yields at most one result and the output does not stall.
// A character that gives both a byte and a final status yields two results, which leave
// one at a time. Input ready is high while the queue has room for two results. Reset
// clears the accumulator, the discard flag and the queue; no clearing pass is needed.
// Depends on b32d_pkg and b32d_result_fifo.
module base32_lowercase_decoder
  import b32d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       last_symbol_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       finished_o,
  output logic [1:0] status_o
);

  logic [6:0]  bits_q, bits_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        disc_q, disc_d;
  logic        accept;
  logic [5:0]  dec;
  logic [3:0]  sum_cnt;
  logic [2:0]  new_cnt;
  logic [11:0] acc;
  logic [11:0] shifted;
  logic [7:0]  mask;
  logic [6:0]  new_bits;
  logic        room;
  push_t       push;
  result_t     res;
  result_t     byte_res;
  result_t     stat_res;

  assign in_ready_o = room;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the character and append its value to the accumulator.
  always_comb begin
    dec      = sym_decode(symbol_i);
    sum_cnt  = {1'b0, cnt_q} + 4'd5;
    acc      = {bits_q, dec[4:0]};
    new_cnt  = (sum_cnt >= 4'd8) ? 3'(sum_cnt - 4'd8) : sum_cnt[2:0];
    shifted  = acc >> new_cnt;
    mask     = (8'd1 << new_cnt) - 8'd1;
    new_bits = acc[6:0] & mask[6:0];
  end

  // Build the results of this transfer and the next accumulator state.
  always_comb begin
    byte_res            = '0;
    byte_res.out_byte   = shifted[7:0];
    byte_res.byte_valid = 1'b1;
    byte_res.status     = ST_OK;
    stat_res            = '0;
    stat_res.finished   = 1'b1;
    stat_res.status     = ST_OK;
    push                = '0;
    push.first          = byte_res;
    push.second         = stat_res;
    bits_d              = bits_q;
    cnt_d               = cnt_q;
    disc_d              = disc_q;
    if (accept) begin
      if (disc_q) begin
        // Swallow the rest of a bad text until its last character.
        if (last_symbol_i) begin
          disc_d = 1'b0;
          bits_d = '0;
          cnt_d  = '0;
        end
      end else if (!dec[5]) begin
        // Invalid character closes the text at once.
        stat_res.status = ST_BAD_CHAR;
        push.count      = 2'd1;
        push.first      = stat_res;
        disc_d          = !last_symbol_i;
        bits_d          = '0;
        cnt_d           = '0;
      end else begin
        bits_d = new_bits;
        cnt_d  = new_cnt;
        if (last_symbol_i) begin
          stat_res.status = (new_bits != 7'd0) ? ST_TRAIL : ST_OK;
          bits_d          = '0;
          cnt_d           = '0;
        end
        if (sum_cnt >= 4'd8) begin
          push.first  = byte_res;
          push.second = stat_res;
          push.count  = last_symbol_i ? 2'd2 : 2'd1;
        end else if (last_symbol_i) begin
          push.first = stat_res;
          push.count = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      disc_q <= disc_d;
    end
  end

  // Result queue parts the two sides of the block.
  b32d_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign out_byte_o   = res.out_byte;
  assign byte_valid_o = res.byte_valid;
  assign finished_o   = res.finished;
  assign status_o     = res.status;

endmodule

### design/b32d_checker.sv
// Port-level checks for the base32 lowercase decoder, bound to the top level.
// Depends on b32d_pkg and base32_lowercase_decoder_assert.svh.
`include "base32_lowercase_decoder_assert.svh"

module b32d_checker
  import b32d_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] symbol_i,
  input logic       last_symbol_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       finished_o,
  input logic [1:0] status_o
);

  logic [8:0]  in_payload;
  logic [11:0] out_payload;
  logic        status_known;

  // Payloads gathered so that each can be checked for stability as a whole.
  assign in_payload   = {symbol_i, last_symbol_i};
  assign out_payload  = {out_byte_o, byte_valid_o, finished_o, status_o};
  assign status_known = (byte_valid_o && status_o == ST_OK) ||
                        (finished_o && status_o <= ST_TRAIL);

  // A stalled input transfer holds its payload.
  `B32D_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_payload))

  // A stalled result holds its payload.
  `B32D_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_payload))

  // A result is either a byte or a final status, never both.
  `B32D_ASSERT_NOW(a_one_kind, out_valid_o, byte_valid_o != finished_o)

  // A byte result carries the ok status and a status result carries a known code.
  `B32D_ASSERT_NOW(a_status_code, out_valid_o, status_known)

  // Input is held back only while results wait in the queue.
  `B32D_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o)

endmodule

bind base32_lowercase_decoder b32d_checker u_b32d_checker (.*);
